@@ src/mgss_pkg.sv @@
package mgss_pkg;

   localparam int SAMPLE_WIDTH = 32;
   localparam int SUM_WIDTH    = 64;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic                           last;
   } req_word_type;

   typedef struct packed {
      logic signed [SUM_WIDTH-1:0] best_sum;
      logic                        too_short;
   } rsp_word_type;

endpackage

@@ src/max_gapped_subsequence_sum_top.sv @@
// channel   direction  ports                             word
// -------   ---------  --------------------------------  ------------------------
// req       in         req_valid req_stall req_word       sample, last
// rsp       out        rsp_valid rsp_stall rsp_word       best_sum, too_short
//
// one sample per cycle unless req_stall is raised; each sample passes through the input register, and
// a result shows at rsp from the edge its last sample leaves that register
// the rate is set by the state update loop: add and compares on the sum width
// reset is synchronous and clears valid flags and the per-sequence state
// a last sample waits in the input register only while a previous result is
// still held at rsp under stall; other samples never wait
module max_gapped_subsequence_sum_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  mgss_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output mgss_pkg::rsp_word_type rsp_word
);
   import mgss_pkg::*;

   localparam logic [1:0] CountTwo   = 2'd2;
   localparam logic [1:0] CountThree = 2'd3;

   // input register
   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff,  in_word_in;

   // per-sequence state
   logic signed [SUM_WIDTH-1:0] prev_ff,   prev_in;
   logic signed [SUM_WIDTH-1:0] prev2_ff,  prev2_in;
   logic signed [SUM_WIDTH-1:0] ending_ff, ending_in;
   logic signed [SUM_WIDTH-1:0] answer_ff, answer_in;
   logic [1:0]                  count_ff,  count_in;

   // result register
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff,  out_word_in;

   logic                        advance;
   logic signed [SUM_WIDTH-1:0] x;
   logic signed [SUM_WIDTH-1:0] prev_plus_x;
   logic signed [SUM_WIDTH-1:0] prefix;
   logic signed [SUM_WIDTH-1:0] base;
   logic signed [SUM_WIDTH-1:0] ending_new;
   logic signed [SUM_WIDTH-1:0] answer_new;

   // a last sample can only leave when the result register is free
   assign advance   = in_valid_ff &&
                      !(in_word_ff.last && out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   assign x = {{(SUM_WIDTH-SAMPLE_WIDTH){in_word_ff.sample[SAMPLE_WIDTH-1]}},
               in_word_ff.sample};

   always_comb begin
      prev_plus_x = prev_ff + x;

      // best non-empty subset sum of the prefix
      if (count_ff == '0) begin
         prefix = x;
      end else begin
         prefix = (prev_ff > x) ? prev_ff : x;
         if (prev_plus_x > prefix) begin
            prefix = prev_plus_x;
         end
      end

      // best gapped selection ending here, from the third sample on
      if (count_ff == CountTwo) begin
         base = prev2_ff;
      end else begin
         base = (ending_ff > prev2_ff) ? ending_ff : prev2_ff;
      end
      ending_new = base + x;

      if (count_ff == CountTwo) begin
         answer_new = ending_new;
      end else begin
         answer_new = (answer_ff > ending_new) ? answer_ff : ending_new;
      end
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_word_in   = in_word_ff;
      prev_in      = prev_ff;
      prev2_in     = prev2_ff;
      ending_in    = ending_ff;
      answer_in    = answer_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      if (advance) begin
         in_valid_in = 1'b0;
         prev2_in    = prev_ff;
         prev_in     = prefix;
         if (count_ff >= CountTwo) begin
            ending_in = ending_new;
            answer_in = answer_new;
         end
         if (count_ff != CountThree) begin
            count_in = count_ff + 2'd1;
         end

         if (in_word_ff.last) begin
            out_valid_in = 1'b1;
            if (count_ff < CountTwo) begin
               out_word_in.best_sum  = '0;
               out_word_in.too_short = 1'b1;
            end else begin
               out_word_in.best_sum  = answer_new;
               out_word_in.too_short = 1'b0;
            end
            // sequence done, back to the reset state
            prev_in   = '0;
            prev2_in  = '0;
            ending_in = '0;
            answer_in = '0;
            count_in  = '0;
         end
      end

      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_word_in  = req_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         prev_ff      <= '0;
         prev2_ff     <= '0;
         ending_ff    <= '0;
         answer_ff    <= '0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         prev_ff      <= prev_in;
         prev2_ff     <= prev2_in;
         ending_ff    <= ending_in;
         answer_ff    <= answer_in;
         count_ff     <= count_in;
      end
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule
